// ===== rtl/assert_macros.svh =====
// Assertion helper macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assert that prop holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("assertion failed: label");
// Assert that cond implies the next-cycle consequence.
`define ASSERT_NEXT(label, clk_s, rst_s, cond, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define ASSERT_ALWAYS(label, clk_s, rst_s, prop)
`define ASSERT_NEXT(label, clk_s, rst_s, cond, cons)
`endif
`endif

// ===== rtl/kvs_pkg.sv =====
// ----------------------------------------------------------------------------
// kvs_pkg
// Types, constants and codes shared by the keyed variable store.
// ----------------------------------------------------------------------------
package kvs_pkg;

    localparam int MaxEntries = 16;
    localparam int MemBytes   = 128;
    localparam int MaxString  = 62;

    localparam int IdxW  = $clog2(MaxEntries);
    localparam int CntW  = $clog2(MaxEntries + 1);
    localparam int AddrW = $clog2(MemBytes);
    localparam int SpanW = AddrW + 1;

    localparam logic [7:0] TypeI = 8'h49;
    localparam logic [7:0] TypeF = 8'h46;
    localparam logic [7:0] TypeC = 8'h43;
    localparam logic [7:0] TypeS = 8'h53;

    typedef enum logic [1:0] {
        REQ_SET_HDR = 2'd0,
        REQ_SET_DATA = 2'd1,
        REQ_GET = 2'd2,
        REQ_DELETE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_FULL = 3'd1,
        ST_ZERO_NAME = 3'd2,
        ST_BAD_TYPE = 3'd3,
        ST_NO_SPACE = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_TOO_LONG = 3'd6,
        ST_UNEXPECTED = 3'd7
    } status_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] var_name;
        logic [7:0] process_id;
        logic [7:0] type_char;
        logic [7:0] string_length;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]       name;
        logic [7:0]       pid;
        logic [7:0]       vtype;
        logic [AddrW-1:0] len;
        logic [AddrW-1:0] addr;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_SHIFT,
        S_DELSCAN,
        S_DELDROP,
        S_PLACE,
        S_FIT,
        S_COMMIT,
        S_GETRD,
        S_GETOUT,
        S_GETLEN,
        S_GETTYPE,
        S_RESP
    } state_t;

endpackage

// ===== rtl/kvs_ram.sv =====
// ----------------------------------------------------------------------------
// kvs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module kvs_ram #(
    parameter int Width = 8,
    parameter int Depth = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/kvs_overlap.sv =====
// ----------------------------------------------------------------------------
// kvs_overlap
// Shared compare unit: span fit and overlap test for one table entry.
// ----------------------------------------------------------------------------
module kvs_overlap import kvs_pkg::*; (
    input  logic [SpanW-1:0] cand,
    input  logic [AddrW-1:0] len,
    input  entry_t           ent,
    output logic             in_range,
    output logic             overlap,
    output logic [SpanW-1:0] ent_end
);

    logic [SpanW:0] cand_end;

    always_comb
    begin
        ent_end  = {1'b0, ent.addr} + {1'b0, ent.len};
        cand_end = {1'b0, cand} + {2'b00, len};
        in_range = cand_end <= (SpanW+1)'(MemBytes);
        // spans overlap when neither is empty and they intersect
        overlap  = (len != '0) && (ent.len != '0)
                   && ({2'b00, ent.addr} < cand_end) && (cand < ent_end);
    end

endmodule

// ===== rtl/keyed_variable_store_allocator.sv =====
// ----------------------------------------------------------------------------
// keyed_variable_store_allocator
// Byte store keyed by variable name and process id with first-fit placement.
// ----------------------------------------------------------------------------
// One request at a time passes through a small sequencer that walks the
// entry table one entry per cycle through a single shared compare unit.
// Data and unexpected-data requests pass through the response state only. A
// set header runs the key search, closes the gap of a replaced entry, and
// then tries (N+1) candidates, each against every entry, for the first-fit
// search (N = live entries, at most 16). A get finds the key, then streams
// each byte (data memory read, then output). A delete compacts the table
// with each drop. A new request is held off while a response waits on a
// stalled output. There is no clearing pass after reset: memory contents
// are undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_variable_store_allocator import kvs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    state_t state_reg, state_next;

    entry_t     table_reg [MaxEntries];
    logic [CntW-1:0] count_reg;
    logic [AddrW:0]  pending_reg;
    logic [AddrW-1:0] waddr_reg;

    in_item_t   req_reg;
    logic [CntW-1:0] i_reg;       // scan index
    logic [IdxW-1:0] j_reg;       // inner scan for placement
    logic [CntW-1:0] cand_idx_reg; // 0 = address 0, k+1 = end of entry k
    logic [SpanW-1:0] cand_reg;
    logic [AddrW-1:0] len_reg;
    logic [SpanW-1:0] best_reg;
    logic             best_ok_reg;
    logic             fit_reg;
    logic [IdxW-1:0]  hit_reg;
    logic [AddrW-1:0] rd_cnt_reg;
    out_item_t        out_reg;
    logic             out_valid_reg;

    // Shared compare unit
    entry_t          cmp_ent;
    logic            cmp_in_range, cmp_overlap;
    logic [SpanW-1:0] cmp_end;

    kvs_overlap u_ov (
        .cand    (cand_reg),
        .len     (len_reg),
        .ent     (cmp_ent),
        .in_range(cmp_in_range),
        .overlap (cmp_overlap),
        .ent_end (cmp_end)
    );

    // Data memory
    logic             mem_we;
    logic [AddrW-1:0] mem_addr;
    logic [7:0]       mem_rdata;

    kvs_ram #(.Width(8), .Depth(MemBytes)) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata(req_reg.data_byte),
        .rdata(mem_rdata)
    );

    logic accept;
    logic out_free;
    logic out_load;
    logic key_hit;
    logic del_hit;
    logic [AddrW-1:0] type_len;
    logic type_ok;
    logic too_long;
    logic [CntW-1:0] last_idx;

    assign out_free  = !out_valid_reg || !out_stall;
    // hold new requests while the sequencer is busy or a response is stuck
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Load the output register in the response states once it is free
    assign out_load = out_free
                      && (state_reg == S_RESP || state_reg == S_GETOUT
                          || state_reg == S_GETTYPE
                          || (state_reg == S_GETLEN && table_reg[hit_reg].vtype == TypeS));

    // During placement the compare unit yields the end of the candidate entry
    assign cmp_ent  = (state_reg == S_PLACE)
                      ? table_reg[cand_idx_reg[IdxW-1:0] - IdxW'(1)]
                      : table_reg[j_reg];
    assign key_hit  = (table_reg[i_reg[IdxW-1:0]].name == req_reg.var_name)
                      && (table_reg[i_reg[IdxW-1:0]].pid == req_reg.process_id);
    assign del_hit  = (table_reg[i_reg[IdxW-1:0]].pid == req_reg.process_id);
    assign last_idx = count_reg - CntW'(1);

    // Size the variable by its type
    always_comb
    begin
        type_ok  = 1'b1;
        too_long = 1'b0;
        type_len = '0;
        unique case (req_reg.type_char)
            TypeI: type_len = AddrW'(2);
            TypeF: type_len = AddrW'(4);
            TypeC: type_len = AddrW'(1);
            TypeS:
            begin
                too_long = req_reg.string_length > 8'(MaxString);
                type_len = req_reg.string_length[AddrW-1:0];
            end
            default: type_ok = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.req_type)
                        REQ_SET_HDR:  state_next = S_FIND;
                        REQ_SET_DATA: state_next = S_RESP;
                        REQ_GET:      state_next = S_FIND;
                        REQ_DELETE:   state_next = S_DELSCAN;
                        default:      state_next = S_RESP;
                    endcase
                end
            end
            S_FIND:
            begin
                if (req_reg.req_type == REQ_SET_HDR
                    && (count_reg >= CntW'(MaxEntries) || req_reg.var_name == '0))
                begin
                    state_next = S_RESP;
                end
                else if (i_reg >= count_reg)
                begin
                    if (req_reg.req_type == REQ_GET)
                        state_next = S_RESP;
                    else if (!type_ok || too_long)
                        state_next = S_RESP;
                    else
                        state_next = S_PLACE;
                end
                else if (key_hit)
                begin
                    state_next = (req_reg.req_type == REQ_GET) ? S_GETRD : S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (i_reg + CntW'(1) >= last_idx || last_idx == '0)
                    state_next = (!type_ok || too_long) ? S_RESP : S_PLACE;
            end
            S_DELSCAN:
            begin
                if (i_reg >= count_reg)
                    state_next = S_RESP;
                else if (del_hit)
                    state_next = S_DELDROP;
            end
            S_DELDROP:
            begin
                if (!({1'b0, j_reg} + CntW'(1) < count_reg))
                    state_next = S_DELSCAN;
            end
            S_PLACE:
            begin
                if (cand_idx_reg > count_reg)
                    state_next = S_COMMIT;
                else
                    state_next = S_FIT;
            end
            S_FIT:
            begin
                if ({1'b0, j_reg} >= count_reg || !fit_reg)
                    state_next = S_PLACE;
            end
            S_COMMIT:  state_next = S_RESP;
            S_GETRD:
            begin
                if (out_free)
                    state_next = (rd_cnt_reg == table_reg[hit_reg].len) ? S_GETLEN : S_GETOUT;
            end
            S_GETOUT:
            begin
                if (out_free)
                    state_next = S_GETRD;
            end
            S_GETLEN:
            begin
                if (out_free)
                    state_next = S_GETTYPE;
            end
            S_GETTYPE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Memory address and write strobe
    always_comb
    begin
        mem_we   = 1'b0;
        mem_addr = waddr_reg;
        if (state_reg == S_RESP && req_reg.req_type == REQ_SET_DATA
            && pending_reg != '0 && out_free)
        begin
            mem_we = 1'b1;
        end
        if (state_reg == S_GETRD)
        begin
            mem_addr = table_reg[hit_reg].addr + rd_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pending_reg   <= '0;
            waddr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg     <= in_data;
                        i_reg       <= '0;
                        j_reg       <= '0;
                        best_ok_reg <= 1'b0;
                        rd_cnt_reg  <= '0;
                        // headers and deletes cancel outstanding data
                        if (in_data.req_type == REQ_SET_HDR
                            || in_data.req_type == REQ_DELETE)
                            pending_reg <= '0;
                    end
                end
                S_FIND:
                begin
                    if (req_reg.req_type == REQ_SET_HDR
                        && count_reg >= CntW'(MaxEntries))
                    begin
                        out_reg <= '{status: ST_FULL, out_byte: '0, last: 1'b1};
                    end
                    else if (req_reg.req_type == REQ_SET_HDR && req_reg.var_name == '0)
                    begin
                        out_reg <= '{status: ST_ZERO_NAME, out_byte: '0, last: 1'b1};
                    end
                    else if (i_reg >= count_reg)
                    begin
                        if (req_reg.req_type == REQ_GET)
                            out_reg <= '{status: ST_NOT_FOUND, out_byte: '0, last: 1'b1};
                        else if (!type_ok)
                            out_reg <= '{status: ST_BAD_TYPE, out_byte: '0, last: 1'b1};
                        else if (too_long)
                            out_reg <= '{status: ST_TOO_LONG, out_byte: '0, last: 1'b1};
                        len_reg      <= type_len;
                        cand_idx_reg <= '0;
                    end
                    else if (key_hit)
                    begin
                        hit_reg <= i_reg[IdxW-1:0];
                        if (req_reg.req_type == REQ_SET_HDR)
                        begin
                            len_reg      <= type_len;
                            cand_idx_reg <= '0;
                            if (!type_ok)
                                out_reg <= '{status: ST_BAD_TYPE, out_byte: '0, last: 1'b1};
                            else if (too_long)
                                out_reg <= '{status: ST_TOO_LONG, out_byte: '0, last: 1'b1};
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + CntW'(1);
                    end
                end
                S_SHIFT:
                begin
                    // advance the tail down one slot per cycle
                    if (last_idx != '0 && i_reg + CntW'(1) < CntW'(MaxEntries))
                        table_reg[i_reg[IdxW-1:0]] <= table_reg[i_reg[IdxW-1:0] + IdxW'(1)];
                    i_reg <= i_reg + CntW'(1);
                    if (i_reg + CntW'(1) >= last_idx || last_idx == '0)
                        count_reg <= last_idx;
                end
                S_DELSCAN:
                begin
                    if (i_reg >= count_reg)
                        out_reg <= '{status: ST_OK, out_byte: '0, last: 1'b1};
                    else if (del_hit)
                        j_reg <= i_reg[IdxW-1:0];
                    else
                        i_reg <= i_reg + CntW'(1);
                end
                S_DELDROP:
                begin
                    // drop: pull next entry into this slot, one per cycle
                    if ({1'b0, j_reg} + CntW'(1) < count_reg)
                    begin
                        table_reg[j_reg] <= table_reg[j_reg + IdxW'(1)];
                        j_reg <= j_reg + IdxW'(1);
                    end
                    else
                    begin
                        count_reg <= last_idx;
                    end
                end
                S_PLACE:
                begin
                    j_reg   <= '0;
                    fit_reg <= 1'b1;
                    if (cand_idx_reg == '0)
                        cand_reg <= '0;
                    else
                        cand_reg <= cmp_end;
                    cand_idx_reg <= cand_idx_reg + CntW'(1);
                end
                S_FIT:
                begin
                    if ({1'b0, j_reg} >= count_reg)
                    begin
                        if (fit_reg && cmp_in_range
                            && (!best_ok_reg || cand_reg < best_reg))
                        begin
                            best_reg    <= cand_reg;
                            best_ok_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        if (cmp_overlap || !cmp_in_range)
                            fit_reg <= 1'b0;
                        j_reg <= j_reg + IdxW'(1);
                    end
                end
                S_COMMIT:
                begin
                    if (best_ok_reg)
                    begin
                        table_reg[count_reg[IdxW-1:0]] <= '{name: req_reg.var_name,
                            pid: req_reg.process_id, vtype: req_reg.type_char,
                            len: len_reg, addr: best_reg[AddrW-1:0]};
                        count_reg   <= count_reg + CntW'(1);
                        pending_reg <= {1'b0, len_reg};
                        waddr_reg   <= (len_reg != '0)
                                       ? best_reg[AddrW-1:0] + len_reg - AddrW'(1)
                                       : best_reg[AddrW-1:0];
                        out_reg <= '{status: ST_OK, out_byte: '0, last: 1'b1};
                    end
                    else
                    begin
                        out_reg <= '{status: ST_NO_SPACE, out_byte: '0, last: 1'b1};
                    end
                end
                S_GETRD:
                begin
                    if (out_free)
                        rd_cnt_reg <= rd_cnt_reg + AddrW'(1);
                end
                S_GETOUT:
                begin
                    if (out_free)
                        out_reg <= '{status: ST_OK, out_byte: mem_rdata, last: 1'b0};
                end
                S_GETLEN:
                begin
                    if (out_free && table_reg[hit_reg].vtype == TypeS)
                    begin
                        out_reg <= '{status: ST_OK,
                            out_byte: 8'(table_reg[hit_reg].len), last: 1'b0};
                    end
                end
                S_GETTYPE:
                begin
                    if (out_free)
                    begin
                        out_reg <= '{status: ST_OK,
                            out_byte: table_reg[hit_reg].vtype, last: 1'b1};
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        if (req_reg.req_type == REQ_SET_DATA)
                        begin
                            if (pending_reg == '0)
                                out_reg <= '{status: ST_UNEXPECTED, out_byte: '0, last: 1'b1};
                            else
                            begin
                                out_reg <= '{status: ST_OK, out_byte: '0, last: 1'b1};
                                pending_reg <= pending_reg - (AddrW+1)'(1);
                                if (waddr_reg != '0)
                                    waddr_reg <= waddr_reg - AddrW'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CntW'(MaxEntries))
    `ASSERT_ALWAYS(a_busy_stall, clk, rst_n, state_reg == S_IDLE || in_stall)
    `ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall, $stable(out_data) && out_valid)
    `ASSERT_ALWAYS(a_pending_bound, clk, rst_n, pending_reg <= (AddrW+1)'(MemBytes))

endmodule

// ===== verif/tb_keyed_variable_store_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_variable_store_allocator
// Self-checking bench for the keyed variable store with first-fit placement.
// A queue of requests feeds a clocked driver. A scoreboard model of the
// table and data memory predicts every response, and a clocked monitor
// compares each accepted response with the oldest prediction. The run goes
// through several idling phases, one long receiver hold-off and full drains.
// ----------------------------------------------------------------------------
module tb_keyed_variable_store_allocator;
    import kvs_pkg::*;

    // Shadow of the store: table, data memory and the pending data window.
    // The written mask is only consulted by the stimulus side, so that a get
    // never reads bytes that were never stored.
    typedef struct {
        int unsigned nm [MaxEntries];
        int unsigned pd [MaxEntries];
        int unsigned ty [MaxEntries];
        int unsigned ln [MaxEntries];
        int unsigned ad [MaxEntries];
        int unsigned cnt;
        logic [7:0]  mem [MemBytes];
        bit          wr [MemBytes];
        int unsigned pend;
        int unsigned waddr;
    } store_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    store_t    stim_store;      // advanced as requests are queued
    store_t    score_store;     // advanced as requests are accepted
    in_item_t  pending_reqs[$];
    out_item_t expected_resp[$];

    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    bit        hold_start = 1'b0;
    bit        hold_taken = 1'b0;
    int        hold_left = 0;
    logic      in_fire = 1'b0;
    int        quiet_cycles = 0;
    int        n_reqs = 0;
    int        n_resps = 0;
    int        n_errors = 0;
    int        n_gets_found = 0;

    keyed_variable_store_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Store model
    // ------------------------------------------------------------------
    function automatic int find_key(ref store_t s, input int unsigned n, input int unsigned p);
        for (int i = 0; i < s.cnt; i++)
            if (s.nm[i] == n && s.pd[i] == p)
                return i;
        return -1;
    endfunction

    // Remove one entry and close the gap, keeping insertion order.
    function automatic void drop_entry(ref store_t s, input int unsigned idx);
        for (int unsigned i = idx; i + 1 < s.cnt; i++)
        begin
            s.nm[i] = s.nm[i + 1];
            s.pd[i] = s.pd[i + 1];
            s.ty[i] = s.ty[i + 1];
            s.ln[i] = s.ln[i + 1];
            s.ad[i] = s.ad[i + 1];
        end
        if (s.cnt > 0)
            s.cnt--;
    endfunction

    function automatic bit span_free(ref store_t s, input int unsigned start,
                                     input int unsigned len);
        if (start + len > MemBytes)
            return 1'b0;
        for (int i = 0; i < s.cnt; i++)
            if (len > 0 && s.ln[i] > 0 && s.ad[i] < start + len && start < s.ad[i] + s.ln[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Lowest fitting start among address zero and every entry end; -1 if none.
    function automatic int first_fit(ref store_t s, input int unsigned len);
        int best;
        int unsigned c;
        best = -1;
        if (span_free(s, 0, len))
            return 0;
        for (int i = 0; i < s.cnt; i++)
        begin
            c = s.ad[i] + s.ln[i];
            if ((best < 0 || c < best) && span_free(s, c, len))
                best = c;
        end
        return best;
    endfunction

    function automatic status_t store_header(ref store_t s, input in_item_t it);
        int idx;
        int at;
        int unsigned len;
        s.pend = 0;
        if (s.cnt >= MaxEntries)
            return ST_FULL;
        if (it.var_name == 8'd0)
            return ST_ZERO_NAME;
        idx = find_key(s, it.var_name, it.process_id);
        if (idx >= 0)
            drop_entry(s, idx);
        case (it.type_char)
            TypeI: len = 2;
            TypeF: len = 4;
            TypeC: len = 1;
            TypeS:
            begin
                if (it.string_length > MaxString)
                    return ST_TOO_LONG;
                len = it.string_length;
            end
            default: return ST_BAD_TYPE;
        endcase
        at = first_fit(s, len);
        if (at < 0)
            return ST_NO_SPACE;
        s.nm[s.cnt] = it.var_name;
        s.pd[s.cnt] = it.process_id;
        s.ty[s.cnt] = it.type_char;
        s.ln[s.cnt] = len;
        s.ad[s.cnt] = at;
        s.cnt++;
        s.pend = len;
        s.waddr = (len > 0) ? at + len - 1 : at;
        return ST_OK;
    endfunction

    // Work out every response that one request produces.
    function automatic void serve_request(ref store_t s, input in_item_t it,
                                          ref out_item_t resp[$]);
        int idx;
        int unsigned total;
        int unsigned k;
        resp.delete();
        case (req_t'(it.req_type))
            REQ_SET_HDR:
                resp.push_back('{status: store_header(s, it), out_byte: 8'd0, last: 1'b1});
            REQ_SET_DATA:
            begin
                if (s.pend == 0)
                    resp.push_back('{status: ST_UNEXPECTED, out_byte: 8'd0, last: 1'b1});
                else
                begin
                    if (s.waddr < MemBytes)
                    begin
                        s.mem[s.waddr] = it.data_byte;
                        s.wr[s.waddr] = 1'b1;
                    end
                    s.pend--;
                    if (s.waddr > 0)
                        s.waddr--;
                    resp.push_back('{status: ST_OK, out_byte: 8'd0, last: 1'b1});
                end
            end
            REQ_GET:
            begin
                idx = find_key(s, it.var_name, it.process_id);
                if (idx < 0)
                    resp.push_back('{status: ST_NOT_FOUND, out_byte: 8'd0, last: 1'b1});
                else
                begin
                    total = s.ln[idx] + ((s.ty[idx] == TypeS) ? 2 : 1);
                    k = 0;
                    for (int unsigned i = 0; i < s.ln[idx]; i++)
                    begin
                        k++;
                        resp.push_back('{status: ST_OK, out_byte: s.mem[s.ad[idx] + i],
                                         last: (k == total)});
                    end
                    if (s.ty[idx] == TypeS)
                    begin
                        k++;
                        resp.push_back('{status: ST_OK, out_byte: s.ln[idx][7:0],
                                         last: (k == total)});
                    end
                    resp.push_back('{status: ST_OK, out_byte: s.ty[idx][7:0], last: 1'b1});
                end
            end
            default:
            begin
                // delete: drop every entry of this process
                int unsigned i;
                i = 0;
                s.pend = 0;
                while (i < s.cnt)
                    if (s.pd[i] == it.process_id)
                        drop_entry(s, i);
                    else
                        i++;
                resp.push_back('{status: ST_OK, out_byte: 8'd0, last: 1'b1});
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Queue one request and advance the stimulus-side shadow with it.
    task automatic queue_req(input in_item_t it);
        out_item_t scratch[$];
        serve_request(stim_store, it, scratch);
        pending_reqs.push_back(it);
    endtask

    // Fresh request with random filler in the fields the operation ignores.
    function automatic in_item_t noise_req(input req_t r);
        in_item_t it;
        logic [63:0] fill;
        fill = {$urandom, $urandom};
        it = fill[$bits(in_item_t)-1:0];
        it.req_type = r;
        return it;
    endfunction

    // Set header followed by n_bytes data requests.
    task automatic queue_set(input int unsigned nm, input int unsigned pid,
                             input logic [7:0] ty, input int unsigned slen,
                             input int n_bytes);
        in_item_t it;
        it = noise_req(REQ_SET_HDR);
        it.var_name = 8'(nm);
        it.process_id = 8'(pid);
        it.type_char = ty;
        it.string_length = 8'(slen);
        queue_req(it);
        for (int i = 0; i < n_bytes; i++)
        begin
            it = noise_req(REQ_SET_DATA);
            queue_req(it);
        end
    endtask

    // A get is allowed unless it would read a byte that was never stored.
    function automatic bit get_is_safe(input int unsigned nm, input int unsigned pid);
        int idx;
        idx = find_key(stim_store, nm, pid);
        if (idx < 0)
            return 1'b1;
        for (int unsigned a = 0; a < stim_store.ln[idx]; a++)
            if (!stim_store.wr[stim_store.ad[idx] + a])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_get(input int unsigned nm, input int unsigned pid);
        in_item_t it;
        if (get_is_safe(nm, pid))
        begin
            it = noise_req(REQ_GET);
            it.var_name = 8'(nm);
            it.process_id = 8'(pid);
            queue_req(it);
        end
    endtask

    task automatic queue_delete(input int unsigned pid);
        in_item_t it;
        it = noise_req(REQ_DELETE);
        it.process_id = 8'(pid);
        queue_req(it);
    endtask

    function automatic int unsigned pick_name();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
    endfunction

    function automatic int unsigned pick_pid();
        return ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 2);
    endfunction

    // Random traffic: mostly well-formed set/get sequences, some noise.
    task automatic queue_random(input int n_target);
        int unsigned r;
        int unsigned nm;
        int unsigned pid;
        int unsigned slen;
        int          nb;
        int          base;
        logic [7:0]  ty;
        in_item_t    it;
        base = pending_reqs.size();
        while (pending_reqs.size() - base < n_target)
        begin
            r = $urandom_range(0, 99);
            nm = pick_name();
            pid = pick_pid();
            if (r < 42)
            begin
                case ($urandom_range(0, 3))
                    0: begin ty = TypeI; nb = 2; end
                    1: begin ty = TypeF; nb = 4; end
                    2: begin ty = TypeC; nb = 1; end
                    default: begin ty = TypeS; nb = $urandom_range(0, 12); end
                endcase
                slen = (ty == TypeS) ? nb : $urandom_range(0, 255);
                if ($urandom_range(0, 9) == 0)
                    nb = $urandom_range(0, nb);     // cut short
                queue_set(nm, pid, ty, slen, nb);
            end
            else if (r < 64)
            begin
                // favour keys that are present
                if (stim_store.cnt > 0 && $urandom_range(0, 3) != 0)
                begin
                    int k;
                    k = $urandom_range(0, stim_store.cnt - 1);
                    queue_get(stim_store.nm[k], stim_store.pd[k]);
                end
                else
                    queue_get(nm, pid);
            end
            else if (r < 70)
                queue_delete(pid);
            else if (r < 75)
            begin
                // burst of empty strings to run the table up to full
                for (int i = 0; i < $urandom_range(4, 9); i++)
                    queue_set($urandom_range(1, 255), $urandom_range(0, 255), TypeS, 0, 0);
            end
            else if (r < 80)
            begin
                slen = $urandom_range(30, MaxString);
                queue_set(nm, pid, TypeS, slen, slen);
            end
            else if (r < 90)
            begin
                // rejected header, data following it is unexpected
                case ($urandom_range(0, 2))
                    0: queue_set(0, pid, TypeC, 0, $urandom_range(0, 2));
                    1: queue_set(nm, pid, TypeS, $urandom_range(MaxString + 1, 255),
                                 $urandom_range(0, 2));
                    default: queue_set(nm, pid, 8'($urandom_range(0, 255)),
                                       $urandom_range(0, 255), $urandom_range(0, 2));
                endcase
            end
            else
            begin
                it = noise_req(req_t'($urandom_range(0, 3)));
                if (it.req_type == REQ_GET && !get_is_safe(it.var_name, it.process_id))
                    it.req_type = REQ_DELETE;
                queue_req(it);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_resp.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: present requests at the falling edge, hold them while stalled
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
                void'(pending_reqs.pop_front());
            if (!in_valid || in_fire)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_reqs[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, or one long hold-off counted here.
    always @(negedge clk)
    begin
        if (hold_start && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on request acceptance, check on response acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t resp[$];
        out_item_t want;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                serve_request(score_store, in_data, resp);
                if (in_data.req_type == REQ_GET && resp.size() > 1)
                    n_gets_found++;
                foreach (resp[i])
                    expected_resp.push_back(resp[i]);
                n_reqs++;
            end
            if (out_valid && !out_stall)
            begin
                n_resps++;
                if (expected_resp.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: response with none expected: got %h", $time, out_data);
                end
                else
                begin
                    want = expected_resp.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        n_errors++;
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, out_data.status);
                    end
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        n_errors++;
                        $display("%0t: out_byte expected %h got %h", $time,
                                 want.out_byte, out_data.out_byte);
                    end
                    if (out_data.last !== want.last)
                    begin
                        n_errors++;
                        $display("%0t: last expected %b got %b", $time,
                                 want.last, out_data.last);
                    end
                end
            end
            // watchdog on cycles with no handshake at all
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= 20000)
            begin
                $display("tb_keyed_variable_store_allocator: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        in_item_t it;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: each type, extremes of key and data, rejections other than full.
        queue_set(255, 255, TypeI, 0, 0);
        it = noise_req(REQ_SET_DATA); it.data_byte = 8'hFF; queue_req(it);
        it = noise_req(REQ_SET_DATA); it.data_byte = 8'h00; queue_req(it);
        queue_get(255, 255);
        queue_set(1, 0, TypeF, 0, 4);
        queue_set(2, 0, TypeC, 0, 1);
        queue_set(3, 1, TypeS, 3, 3);
        queue_set(4, 1, TypeS, 0, 0);           // empty string takes no bytes
        queue_get(3, 1);
        queue_get(4, 1);
        queue_set(1, 0, TypeC, 0, 1);           // replace: the freed gap at address 2 reused
        queue_get(1, 0);
        queue_set(0, 0, TypeC, 0, 1);           // zero name, then unexpected data
        queue_set(5, 0, 8'h58, 0, 0);           // unknown type
        queue_set(5, 0, TypeS, MaxString + 1, 0);
        queue_set(5, 0, TypeS, MaxString, MaxString);
        queue_set(6, 0, TypeS, MaxString, 0);   // no space left
        queue_get(9, 9);                        // missing key
        queue_delete(0);
        queue_get(5, 0);
        queue_delete(255);

        // Phase 1: no idling.
        queue_random(60);
        wait_drained();

        // Phase 2: sender idles half the time, and a long receiver hold-off.
        tx_idle_pct = 50;
        hold_start = 1'b1;
        queue_random(90);
        wait_drained();

        // Phase 3: receiver stalls half the time.
        tx_idle_pct = 0;
        rx_stall_pct = 50;
        queue_random(90);
        wait_drained();

        // Phase 4: both idle now and then.
        tx_idle_pct = 28;
        rx_stall_pct = 28;
        queue_random(90);
        wait_drained();

        repeat (400) @(posedge clk);
        $display("covered %0d requests and %0d responses, %0d gets of stored variables",
                 n_reqs, n_resps, n_gets_found);
        $display("phases: no idling, sender idle, receiver stall, both, one long hold-off");
        if (n_errors == 0 && expected_resp.size() == 0)
            $display("tb_keyed_variable_store_allocator: clean");
        else
            $display("tb_keyed_variable_store_allocator: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kvs_pkg.sv
rtl/kvs_ram.sv
rtl/kvs_overlap.sv
rtl/keyed_variable_store_allocator.sv
verif/tb_keyed_variable_store_allocator.sv
